// ===== hdl/ddoc_pkg.sv =====
`timescale 1ns / 1ps

package ddoc_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 22;
    localparam int ACC_W   = 23;
    localparam int DOY_W   = 9;
    localparam int DATA_W  = 48;

    localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
    localparam logic [MONTH_W-1:0] LAST_MON  = 4'd12;
    localparam logic [DOY_W-1:0]   DAYS_YEAR = 9'd365;
    localparam logic [DOY_W-1:0]   DAYS_LEAP = 9'd366;

    // y / 100 as (y * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit years
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [6:0]  CENT_LAST    = 7'd99;

    // configuration register indexes
    localparam logic [1:0] CFG_BASE_YEAR  = 2'd0;
    localparam logic [1:0] CFG_BASE_MONTH = 2'd1;
    localparam logic [1:0] CFG_BASE_DAY   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BEFORE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       div_q;
        logic       div_r;
        logic       base_step;
        logic       base_done;
        logic       year_step;
        logic       mon_step;
        logic       finish;
        logic [1:0] st;
    } ddoc_cmd_t;

    typedef struct packed {
        logic is_cmd1;
        logic mon_lt_bm;
        logic early;
        logic yr_lt_y;
        logic yr_le_max;
        logic rem_ge_ylen;
        logic mon_lt_m;
        logic mon_lt_12;
        logic rem_ge_mlen;
        logic out_busy;
    } ddoc_stat_t;

    function automatic logic [YEAR_W-1:0] fix_year(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] r;
        if (y == '0)
            r = YEAR_W'(1);
        else if (y > MAX_YEAR)
            r = MAX_YEAR;
        else
            r = y;
        return r;
    endfunction

    function automatic logic [MONTH_W-1:0] fix_month(input logic [MONTH_W-1:0] m);
        logic [MONTH_W-1:0] r;
        if (m == '0)
            r = MONTH_W'(1);
        else if (m > LAST_MON)
            r = LAST_MON;
        else
            r = m;
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] fix_day(input logic [DAY_W-1:0] d);
        return (d == '0) ? DAY_W'(1) : d;
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic            leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/ddoc_ctrl.sv =====
`timescale 1ns / 1ps

module ddoc_ctrl
    import ddoc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  ddoc_stat_t stat,
    output ddoc_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INIT_Q = 3'd1;
    localparam logic [2:0] S_INIT_R = 3'd2;
    localparam logic [2:0] S_BASE   = 3'd3;
    localparam logic [2:0] S_YWALK  = 3'd4;
    localparam logic [2:0] S_MWALK  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] st_reg, st_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd        = '0;
        cmd.st     = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    st_next    = ST_OK;
                    state_next = S_INIT_Q;
                end
            end
            S_INIT_Q:
            begin
                cmd.div_q  = 1'b1;
                state_next = S_INIT_R;
            end
            S_INIT_R:
            begin
                cmd.div_r  = 1'b1;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                // sum the base months, then fold in the base day
                if (stat.mon_lt_bm)
                    cmd.base_step = 1'b1;
                else
                begin
                    cmd.base_done = 1'b1;
                    if (!stat.is_cmd1 && stat.early)
                    begin
                        st_next    = ST_BEFORE;
                        state_next = S_FIN;
                    end
                    else
                        state_next = S_YWALK;
                end
            end
            S_YWALK:
            begin
                if (!stat.is_cmd1)
                begin
                    if (stat.yr_lt_y)
                        cmd.year_step = 1'b1;
                    else
                        state_next = S_MWALK;
                end
                else if (stat.yr_le_max && stat.rem_ge_ylen)
                    cmd.year_step = 1'b1;
                else if (!stat.yr_le_max)
                begin
                    st_next    = ST_RANGE;
                    state_next = S_FIN;
                end
                else
                    state_next = S_MWALK;
            end
            S_MWALK:
            begin
                if (!stat.is_cmd1 ? stat.mon_lt_m : (stat.mon_lt_12 && stat.rem_ge_mlen))
                    cmd.mon_step = 1'b1;
                else
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_INIT_Q))
        else $error("accepted item did not start conversion");

    a_range_only_cmd1: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && cmd.st == ST_RANGE) |-> stat.is_cmd1)
        else $error("year range error on a date to offset item");

endmodule

// ===== hdl/ddoc_dp.sv =====
`timescale 1ns / 1ps

module ddoc_dp
    import ddoc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [DATA_W-1:0]   s_tdata,
    input  logic                s_tuser,
    input  logic [YEAR_W-1:0]   base_y,
    input  logic [MONTH_W-1:0]  base_m,
    input  logic [DAY_W-1:0]    base_d,
    input  ddoc_cmd_t           cmd,
    output ddoc_stat_t          stat,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,
    output logic [1:0]          m_tuser
);

    logic                is_cmd1_reg;
    logic [YEAR_W-1:0]   in_y_reg;
    logic [MONTH_W-1:0]  in_m_reg;
    logic [DAY_W-1:0]    in_d_reg;
    logic [OFF_W-1:0]    off_reg;

    logic [YEAR_W-1:0]   yr_reg;
    logic [6:0]          yq_reg;
    logic [6:0]          yr100_reg;
    logic [MONTH_W-1:0]  mon_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [DOY_W-1:0]    bdoy_reg;

    logic                m_tvalid_reg;
    logic [DATA_W-1:0]   m_tdata_reg;
    logic [1:0]          m_tuser_reg;

    logic                leap;
    logic [DOY_W-1:0]    ylen;
    logic [DAY_W-1:0]    mlen;
    logic [DOY_W-1:0]    bdoy_val;
    logic [26:0]         q_prod;
    logic [YEAR_W-1:0]   cent_prod;
    logic [ACC_W-1:0]    off_sum;
    logic [DAY_W-1:0]    day_out;
    logic [DATA_W-1:0]   res_data;

    // y % 4 equals (y % 100) % 4, so the century split gives all three tests
    assign leap = (yr100_reg[1:0] == 2'd0) && ((yr100_reg != '0) || (yq_reg[1:0] == 2'd0));
    assign ylen = leap ? DAYS_LEAP : DAYS_YEAR;
    assign mlen = month_days(mon_reg, leap);

    assign bdoy_val  = acc_reg[DOY_W-1:0] + DOY_W'(base_d) - DOY_W'(1);
    assign q_prod    = 27'(yr_reg) * 27'(DIV100_MUL);
    assign cent_prod = YEAR_W'(yq_reg) * YEAR_W'(100);
    assign off_sum   = acc_reg + ACC_W'(in_d_reg) - ACC_W'(1) - ACC_W'(bdoy_reg);
    assign day_out   = acc_reg[DAY_W-1:0] + DAY_W'(1);

    always_comb
    begin
        stat.is_cmd1     = is_cmd1_reg;
        stat.mon_lt_bm   = (mon_reg < base_m);
        stat.early       = (in_y_reg < base_y)
                        || ((in_y_reg == base_y) && (in_m_reg < base_m))
                        || ((in_y_reg == base_y) && (in_m_reg == base_m) && (in_d_reg < base_d));
        stat.yr_lt_y     = (yr_reg < in_y_reg);
        stat.yr_le_max   = (yr_reg <= MAX_YEAR);
        stat.rem_ge_ylen = (acc_reg >= ACC_W'(ylen));
        stat.mon_lt_m    = (mon_reg < in_m_reg);
        stat.mon_lt_12   = (mon_reg < LAST_MON);
        stat.rem_ge_mlen = (acc_reg >= ACC_W'(mlen));
        stat.out_busy    = m_tvalid_reg && !m_tready;
    end

    // result word; error items carry zeros
    always_comb
    begin
        res_data = '0;
        if (cmd.st == ST_OK)
        begin
            if (is_cmd1_reg)
            begin
                res_data[35:22] = yr_reg;
                res_data[39:36] = mon_reg;
                res_data[44:40] = day_out;
            end
            else
                res_data[21:0] = off_sum[OFF_W-1:0];
        end
    end

    // capture and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            is_cmd1_reg <= s_tuser;
            in_y_reg    <= fix_year(s_tdata[13:0]);
            in_m_reg    <= fix_month(s_tdata[17:14]);
            in_d_reg    <= fix_day(s_tdata[22:18]);
            off_reg     <= s_tdata[44:23];
            yr_reg      <= base_y;
            mon_reg     <= MONTH_W'(1);
            acc_reg     <= '0;
        end
        if (cmd.div_q)
            yq_reg <= q_prod[DIV100_SHIFT+6:DIV100_SHIFT];
        if (cmd.div_r)
            yr100_reg <= 7'(yr_reg - cent_prod);
        if (cmd.base_step)
        begin
            acc_reg <= acc_reg + ACC_W'(mlen);
            mon_reg <= mon_reg + MONTH_W'(1);
        end
        if (cmd.base_done)
        begin
            bdoy_reg <= bdoy_val;
            acc_reg  <= is_cmd1_reg ? (ACC_W'(off_reg) + ACC_W'(bdoy_val)) : '0;
            mon_reg  <= MONTH_W'(1);
        end
        if (cmd.year_step)
        begin
            acc_reg <= is_cmd1_reg ? (acc_reg - ACC_W'(ylen)) : (acc_reg + ACC_W'(ylen));
            yr_reg  <= yr_reg + YEAR_W'(1);
            if (yr100_reg == CENT_LAST)
            begin
                yr100_reg <= '0;
                yq_reg    <= yq_reg + 7'd1;
            end
            else
                yr100_reg <= yr100_reg + 7'd1;
        end
        if (cmd.mon_step)
        begin
            acc_reg <= is_cmd1_reg ? (acc_reg - ACC_W'(mlen)) : (acc_reg + ACC_W'(mlen));
            mon_reg <= mon_reg + MONTH_W'(1);
        end
        if (cmd.finish)
        begin
            m_tdata_reg <= res_data;
            m_tuser_reg <= cmd.st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.finish)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_finish_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_tvalid_reg)
        else $error("finished conversion did not raise output valid");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !cmd.finish)
        else $error("pending output item overwritten");

    a_year_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.year_step |-> (yr_reg <= MAX_YEAR))
        else $error("year walk stepped past the last year");

    a_month_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mon_step |-> (mon_reg < LAST_MON))
        else $error("month walk stepped past December");

endmodule

// ===== hdl/date_day_offset_converter.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Handshake          | Payload
// ---------+-----+--------------------+---------------------------------------------
// s_axis   | in  | s_tvalid/s_tready  | tuser: cmd; tdata: year, month, day, offset
// m_axis   | out | m_tvalid/m_tready  | tuser: status; tdata: offset, year, month, day
// cfg      | in  | cfg_we             | cfg_addr: register index; cfg_wdata: value
//
// One item at a time. An item goes through setup (load, century split), the base
// month sums and one step to fold in the base day, a walk over the years (up to
// 9999 of them) and then over the months, and a hand-off to the output register.
// The year walk is the longest part.
// Reset clears the controller and the output valid; the base date returns to
// 1970-01-01. A stalled output item is held in its register; the next input
// item is taken meanwhile, and its result waits for the register to drain.

module date_day_offset_converter
    import ddoc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,   // year[13:0], month[17:14], day[22:18],
                                           // offset[44:23], zero[47:45]
    input  logic                s_tuser,   // cmd[0]

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata,   // result_offset[21:0], result_year[35:22],
                                           // result_month[39:36], result_day[44:40],
                                           // zero[47:45]
    output logic [1:0]          m_tuser,   // status[1:0]

    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [YEAR_W-1:0]   cfg_wdata
);

    logic [YEAR_W-1:0]   base_year_reg;
    logic [MONTH_W-1:0]  base_month_reg;
    logic [DAY_W-1:0]    base_day_reg;

    logic [YEAR_W-1:0]   base_y;
    logic [MONTH_W-1:0]  base_m;
    logic [DAY_W-1:0]    base_d;

    ddoc_cmd_t  cmd;
    ddoc_stat_t stat;

    // Base date registers; an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_year_reg  <= 14'd1970;
            base_month_reg <= 4'd1;
            base_day_reg   <= 5'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_BASE_YEAR:  base_year_reg  <= cfg_wdata;
                CFG_BASE_MONTH: base_month_reg <= cfg_wdata[MONTH_W-1:0];
                CFG_BASE_DAY:   base_day_reg   <= cfg_wdata[DAY_W-1:0];
                default:        ;
            endcase
        end
    end

    // Clamp the base date into range the same way as an input date.
    assign base_y = fix_year(base_year_reg);
    assign base_m = fix_month(base_month_reg);
    assign base_d = fix_day(base_day_reg);

    ddoc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ddoc_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .base_y   (base_y),
        .base_m   (base_m),
        .base_d   (base_d),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ddoc_pkg::*;

    // Item on the input side: cmd travels in tuser, the rest in tdata.
    typedef struct packed {
        logic               cmd;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [OFF_W-1:0]   offset;
    } date_req_t;

    // Item on the output side: status travels in tuser, the rest in tdata.
    typedef struct packed {
        logic [OFF_W-1:0]   offset;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [1:0]         status;
    } date_res_t;

    typedef enum logic {ROW_ITEM, ROW_BASE} row_kind_t;

    // One row of the directed plan. ROW_BASE rewrites the base date from
    // req.year/month/day; ROW_ITEM sends req, checked against exp when typed.
    typedef struct packed {
        row_kind_t kind;
        date_req_t req;
        logic      typed;
        date_res_t exp;
    } plan_row_t;

    localparam int CMD_TO_OFFSET = 0;
    localparam int CMD_TO_DATE   = 1;

    localparam int RAND_PHASES     = 4;
    localparam int ITEMS_PER_PHASE = 19;
    localparam int LONG_HOLD       = 3000;
    // worst item: full year walk plus setup, both idle bursts
    localparam int ITEM_WORST      = 10100 + 30;
    localparam int END_WAIT        = 10100;
    localparam longint CYCLE_LIMIT =
        longint'(40 + RAND_PHASES * ITEMS_PER_PHASE) * ITEM_WORST * 4 + LONG_HOLD + END_WAIT;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;    // year[13:0], month[17:14], day[22:18],
                                   // offset[44:23], zero[47:45]
    logic              s_tuser;    // cmd[0]
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;    // result_offset[21:0], result_year[35:22],
                                   // result_month[39:36], result_day[44:40],
                                   // zero[47:45]
    logic [1:0]        m_tuser;    // status[1:0]
    logic              cfg_we;
    logic [1:0]        cfg_addr;
    logic [YEAR_W-1:0] cfg_wdata;

    // Shadow copy of the base date registers, as written (not yet clamped).
    logic [YEAR_W-1:0]  base_year_q  = YEAR_W'(1970);
    logic [MONTH_W-1:0] base_month_q = MONTH_W'(1);
    logic [DAY_W-1:0]   base_day_q   = DAY_W'(1);

    date_res_t pending_results[$];
    plan_row_t plan[$];

    int     fail_count   = 0;
    int     results_seen = 0;
    longint cycle_count  = 0;
    bit     quiet        = 1'b0;   // no idling on either side
    bit     hold_req     = 1'b0;   // ask the receiver for one long hold-off

    date_res_t got_res;
    date_res_t want_res;

    date_day_offset_converter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Calendar arithmetic for the predictor
    // ---------------------------------------------------------------------

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_year(input int unsigned y);
        return leap_year(y) ? 366 : 365;
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        int unsigned n;
        case (m)
            2:             n = leap_year(y) ? 29 : 28;
            4, 6, 9, 11:   n = 30;
            default:       n = 31;
        endcase
        return n;
    endfunction

    // Zero-based day within the year; a day past month end just counts on.
    function automatic int unsigned day_index(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
        int unsigned n;
        n = d - 1;
        for (int unsigned i = 1; i < m; i++)
            n += days_in_month(i, y);
        return n;
    endfunction

    // Out-of-range fields are pulled to the nearest legal value.
    function automatic int unsigned clamp_year(input int unsigned y);
        if (y < 1)
            return 1;
        if (y > MAX_YEAR)
            return MAX_YEAR;
        return y;
    endfunction

    function automatic int unsigned clamp_month(input int unsigned m);
        if (m < 1)
            return 1;
        if (m > 12)
            return 12;
        return m;
    endfunction

    function automatic int unsigned clamp_day(input int unsigned d);
        return (d < 1) ? 1 : d;
    endfunction

    // Compute the conversion result for one item under the current base date.
    function automatic date_res_t predict_conversion(input date_req_t q);
        int unsigned by, bm, bd, base_idx;
        int unsigned y, m, d, sum, rem;
        date_res_t   r;
        by       = clamp_year(base_year_q);
        bm       = clamp_month(base_month_q);
        bd       = clamp_day(base_day_q);
        base_idx = day_index(by, bm, bd);
        r        = '0;
        r.status = ST_OK;
        if (q.cmd == CMD_TO_OFFSET)
        begin
            y = clamp_year(q.year);
            m = clamp_month(q.month);
            d = clamp_day(q.day);
            if (y < by || (y == by && m < bm) || (y == by && m == bm && d < bd))
                r.status = ST_BEFORE;
            else
            begin
                sum = 0;
                for (int unsigned i = by; i < y; i++)
                    sum += days_in_year(i);
                // may wrap when the base day runs past its month end
                sum      = sum + day_index(y, m, d) - base_idx;
                r.offset = sum[OFF_W-1:0];
            end
        end
        else
        begin
            rem = int'(q.offset) + base_idx;
            y   = by;
            while (y <= MAX_YEAR && rem >= days_in_year(y))
            begin
                rem -= days_in_year(y);
                y++;
            end
            if (y > MAX_YEAR)
                r.status = ST_RANGE;
            else
            begin
                m = 1;
                while (m < 12 && rem >= days_in_month(m, y))
                begin
                    rem -= days_in_month(m, y);
                    m++;
                end
                r.year  = y[YEAR_W-1:0];
                r.month = m[MONTH_W-1:0];
                r.day   = DAY_W'(rem + 1);
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Plan building and driving
    // ---------------------------------------------------------------------

    function automatic date_req_t make_req(input int c, input int y, input int m, input int d,
                                           input int off);
        date_req_t q;
        q.cmd    = c[0];
        q.year   = YEAR_W'(y);
        q.month  = MONTH_W'(m);
        q.day    = DAY_W'(d);
        q.offset = OFF_W'(off);
        return q;
    endfunction

    task automatic plan_base(input int y, input int m, input int d);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_BASE;
        row.req  = make_req(0, y, m, d, 0);
        plan.push_back(row);
    endtask

    task automatic plan_item(input int c, input int y, input int m, input int d, input int off);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_ITEM;
        row.req  = make_req(c, y, m, d, off);
        plan.push_back(row);
    endtask

    // Same as plan_item, with the result spelled out by hand.
    task automatic plan_known(input int c, input int y, input int m, input int d, input int off,
                              input int e_off, input int e_y, input int e_m, input int e_d,
                              input logic [1:0] e_st);
        plan_row_t row;
        row            = '0;
        row.kind       = ROW_ITEM;
        row.req        = make_req(c, y, m, d, off);
        row.typed      = 1'b1;
        row.exp.offset = OFF_W'(e_off);
        row.exp.year   = YEAR_W'(e_y);
        row.exp.month  = MONTH_W'(e_m);
        row.exp.day    = DAY_W'(e_d);
        row.exp.status = e_st;
        plan.push_back(row);
    endtask

    // Rewrite all three base registers; only called with nothing in flight.
    // Entered and left right after a falling edge.
    task automatic write_base(input int y, input int m, input int d);
        while (pending_results.size() != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_BASE_YEAR;
        cfg_wdata <= YEAR_W'(y);
        @(negedge clk);
        base_year_q = YEAR_W'(y);
        cfg_addr  <= CFG_BASE_MONTH;
        cfg_wdata <= YEAR_W'(m);
        @(negedge clk);
        base_month_q = MONTH_W'(m);
        cfg_addr  <= CFG_BASE_DAY;
        cfg_wdata <= YEAR_W'(d);
        @(negedge clk);
        base_day_q = DAY_W'(d);
        cfg_we <= 1'b0;
    endtask

    // Offer one item, optionally after an idle burst; queue its result once
    // the handshake completes. Entered and left right after a falling edge.
    task automatic send_item(input date_req_t q, input date_res_t want);
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= q.cmd;
        s_tdata  <= {3'b000, q.offset, q.day, q.month, q.year};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(want);
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] result %0d: %s got %0d expected %0d", $time, results_seen, what, got, want);
        fail_count++;
    endtask

    // ---------------------------------------------------------------------
    // Receiver: random stall bursts, one long hold-off on request
    // ---------------------------------------------------------------------

    initial
    begin
        int stall_left;
        int hold_left;
        bit hold_taken;
        stall_left = 0;
        hold_left  = 0;
        hold_taken = 1'b0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (quiet)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------------
    // Result checking against the oldest queued expectation
    // ---------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res.offset = m_tdata[OFF_W-1:0];
            got_res.year   = m_tdata[22 +: YEAR_W];
            got_res.month  = m_tdata[36 +: MONTH_W];
            got_res.day    = m_tdata[40 +: DAY_W];
            got_res.status = m_tuser;
            if (pending_results.size() == 0)
                report_mismatch("result with nothing pending, status", got_res.status, 0);
            else
            begin
                want_res = pending_results.pop_front();
                if (got_res.status !== want_res.status)
                    report_mismatch("status", got_res.status, want_res.status);
                if (got_res.offset !== want_res.offset)
                    report_mismatch("result_offset", got_res.offset, want_res.offset);
                if (got_res.year !== want_res.year)
                    report_mismatch("result_year", got_res.year, want_res.year);
                if (got_res.month !== want_res.month)
                    report_mismatch("result_month", got_res.month, want_res.month);
                if (got_res.day !== want_res.day)
                    report_mismatch("result_day", got_res.day, want_res.day);
            end
            results_seen++;
        end
    end

    // Watchdog: end a hung run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------

    initial
    begin
        date_req_t   q;
        date_res_t   want;
        int          yy;
        int unsigned by;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_BASE_YEAR;
        cfg_wdata = '0;

        // Directed plan; base date starts at its reset value 1970-01-01.
        plan_known(CMD_TO_OFFSET, 1970, 1, 1, 0,      0, 0, 0, 0, ST_OK);
        plan_known(CMD_TO_DATE, 0, 0, 0, 0,           0, 1970, 1, 1, ST_OK);
        plan_known(CMD_TO_OFFSET, 1969, 12, 31, 0,    0, 0, 0, 0, ST_BEFORE);
        plan_known(CMD_TO_DATE, 0, 0, 0, 3652058,     0, 0, 0, 0, ST_RANGE);
        plan_known(CMD_TO_DATE, 16383, 15, 31, 4194303, 0, 0, 0, 0, ST_RANGE);
        // zero year, month and day read as 0001-01-01, well before the base
        plan_known(CMD_TO_OFFSET, 0, 0, 0, 0,         0, 0, 0, 0, ST_BEFORE);
        plan_item(CMD_TO_OFFSET, 2000, 2, 29, 0);      // leap by the 400 rule
        plan_item(CMD_TO_OFFSET, 2100, 3, 1, 0);       // not leap by the 100 rule
        plan_item(CMD_TO_OFFSET, 1970, 2, 31, 0);      // day past month end
        plan_item(CMD_TO_OFFSET, 16383, 15, 31, 0);    // clamps to 9999-12-31
        plan_item(CMD_TO_DATE, 0, 0, 0, 10957);

        plan_base(1, 1, 1);
        plan_known(CMD_TO_DATE, 0, 0, 0, 3652058,     0, 9999, 12, 31, ST_OK);
        plan_known(CMD_TO_DATE, 0, 0, 0, 3652059,     0, 0, 0, 0, ST_RANGE);
        plan_known(CMD_TO_OFFSET, 9999, 12, 31, 0,    3652058, 0, 0, 0, ST_OK);
        plan_known(CMD_TO_OFFSET, 1, 1, 1, 0,         0, 0, 0, 0, ST_OK);

        // zero base fields read as 0001-01-01
        plan_base(0, 0, 0);
        plan_known(CMD_TO_DATE, 0, 0, 0, 0,           0, 1, 1, 1, ST_OK);

        // oversized base fields clamp to 9999-12-31
        plan_base(16383, 15, 31);
        plan_known(CMD_TO_DATE, 0, 0, 0, 0,           0, 9999, 12, 31, ST_OK);
        plan_known(CMD_TO_DATE, 0, 0, 0, 1,           0, 0, 0, 0, ST_RANGE);
        plan_known(CMD_TO_OFFSET, 9999, 12, 30, 0,    0, 0, 0, 0, ST_BEFORE);
        plan_known(CMD_TO_OFFSET, 16383, 15, 31, 0,   0, 0, 0, 0, ST_OK);

        // base day past month end: an early-March date wraps the offset
        plan_base(2023, 2, 31);
        plan_item(CMD_TO_OFFSET, 2023, 3, 1, 0);
        plan_item(CMD_TO_OFFSET, 2023, 3, 3, 0);
        plan_item(CMD_TO_DATE, 0, 0, 0, 0);
        plan_item(CMD_TO_OFFSET, 2024, 2, 29, 0);

        plan_base(2000, 2, 29);
        plan_item(CMD_TO_DATE, 0, 0, 0, 366);
        plan_known(CMD_TO_OFFSET, 2000, 2, 28, 0,     0, 0, 0, 0, ST_BEFORE);

        // Hold reset, then release it on a falling edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed plan.
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_BASE)
            begin
                s_tvalid <= 1'b0;
                write_base(plan[i].req.year, plan[i].req.month, plan[i].req.day);
            end
            else
            begin
                want = plan[i].typed ? plan[i].exp : predict_conversion(plan[i].req);
                send_item(plan[i].req, want);
            end
        end

        // Random phases, each under a fresh base date.
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            s_tvalid <= 1'b0;
            case (phase)
                1:       write_base($urandom_range(0, 16383), $urandom_range(0, 15),
                                    $urandom_range(0, 31));
                3:       write_base($urandom_range(9950, 9999), $urandom_range(1, 12),
                                    $urandom_range(1, 31));
                default: write_base($urandom_range(1, 9999), $urandom_range(1, 12),
                                    $urandom_range(1, 31));
            endcase
            // fill the block behind a stalled receiver in the first phase
            if (phase == 0)
                hold_req = 1'b1;
            // last phase runs with both sides always ready
            if (phase == RAND_PHASES - 1)
                quiet = 1'b1;
            by = clamp_year(base_year_q);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // unused fields carry random bits as well
                q.cmd    = 1'($urandom);
                q.year   = YEAR_W'($urandom);
                q.month  = MONTH_W'($urandom);
                q.day    = DAY_W'($urandom);
                q.offset = OFF_W'($urandom);
                if ($urandom_range(0, 99) < 88)
                begin
                    // keep year walks short: dates and offsets near the base
                    if (q.cmd == CMD_TO_OFFSET)
                    begin
                        yy = int'(by) + int'($urandom_range(0, 60)) - 20;
                        if (yy < 1)
                            yy = 1;
                        if (yy > MAX_YEAR)
                            yy = MAX_YEAR;
                        q.year  = YEAR_W'(yy);
                        q.month = MONTH_W'($urandom_range(1, 12));
                        q.day   = DAY_W'($urandom_range(1, 31));
                    end
                    else
                        q.offset = OFF_W'($urandom_range(0, 15000));
                end
                send_item(q, predict_conversion(q));
            end
        end

        // Drain, then give the block time to show any stray result.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (END_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
